>>> src/lpr_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the length-prefixed packet ring.
package lpr_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_COMMIT,
    S_POP,
    S_HDR,
    S_RD,
    S_EMIT,
    S_RESP
  } state_t;

  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_EMPTY  = 2'd1;
  localparam logic [1:0] STAT_BUSY   = 2'd2;
  localparam logic [1:0] STAT_REJECT = 2'd3;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
    logic       end_of_packet;
    logic       link_busy;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic [1:0] status;
    logic [6:0] free_space;
  } out_item_t;

endpackage

>>> src/length_prefixed_packet_ring.sv
`timescale 1ns / 1ps
// Top level of the length-prefixed packet ring: sequencer, index state and result register.
//
// A byte ring of RING_DEPTH entries holds whole packets, each as one header byte (payload
// length plus one) followed by the payload. A push transaction brings one payload byte and
// always yields one result; the byte flagged end_of_packet commits the packet, or rejects
// it with status 3 when header plus payload would not stay strictly below the free space
// (the ring is never allowed to become exactly full). A pop transaction streams the oldest
// packet out one result per payload byte, with last on the final byte, or yields a single
// status result when the link is busy (status 2) or the ring is empty (status 1).
// free_space always reports the value after the transaction, modulo 128. The block works
// on one transaction at a time and holds item_stall high while busy. A push stages its byte in
// S_PUSH, writes the header in S_COMMIT when end_of_packet is set and answers in S_RESP; a pop
// reads the header in S_POP, releases the packet in S_HDR, then passes S_RD and S_EMIT for each
// byte, or S_RESP if refused; the store has a registered read and one index adder serves all.
// The result register frees the sequencer as soon as a result is parked there.
module length_prefixed_packet_ring #(
  parameter int RING_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  lpr_pkg::in_item_t item,
  output logic              result_valid,
  input  logic              result_stall,
  output lpr_pkg::out_item_t result
);
  import lpr_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);
  localparam int CW = $clog2(RING_DEPTH + 1);
  localparam int WW = CW + 8;

  // Sequencer and index state
  state_t         state, state_next;
  logic [AW-1:0]  rd_idx, rd_idx_next;
  logic [AW-1:0]  wr_idx, wr_idx_next;
  logic [CW-1:0]  used, used_next;       // bytes held by committed packets
  logic [CW-1:0]  pcount, pcount_next;   // payload bytes staged for the open packet
  logic           povf, povf_next;       // open packet no longer fits
  in_item_t       cur, cur_next;         // transaction being worked on
  logic [1:0]     resp_status, resp_status_next;
  logic [CW-1:0]  n_left, n_left_next;   // payload bytes still to stream
  logic [AW-1:0]  ptr, ptr_next;         // store address of the byte last read
  out_item_t      result_next;
  logic           load_res;

  // Store and shared adder hookup
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;
  logic           mem_re;
  logic [AW-1:0]  mem_raddr;
  logic [7:0]     mem_rdata;
  logic [AW-1:0]  add_a;
  logic [CW-1:0]  add_b;
  logic [AW-1:0]  add_sum;

  // Derived values
  logic [CW-1:0]  free_cnt;
  logic [CW+6:0]  free_wide;
  logic [6:0]     free7;
  logic           fits;
  logic           out_free;
  logic [WW-1:0]  hdr_len;
  logic [WW-1:0]  hdr_lim;
  logic [WW-1:0]  hdr_cl;
  logic [CW-1:0]  n_clamp;
  logic [CW+7:0]  hdr_wide;

  lpr_ring_mem #(
    .DEPTH(RING_DEPTH),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  lpr_mod_add #(
    .DEPTH(RING_DEPTH),
    .AW   (AW),
    .CW   (CW)
  ) u_add (
    .a  (add_a),
    .b  (add_b),
    .sum(add_sum)
  );

  assign item_stall = (state != S_IDLE);
  assign out_free   = !result_valid || !result_stall;

  // Free space and its 7-bit report
  assign free_cnt  = CW'(RING_DEPTH) - used;
  assign free_wide = {7'd0, free_cnt};
  assign free7     = free_wide[6:0];

  // Header plus staged bytes plus this byte must stay below the free space
  assign fits = ((CW+1)'(pcount) + (CW+1)'(2)) < (CW+1)'(free_cnt);

  // Header byte for the packet being committed
  assign hdr_wide = {8'd0, pcount + CW'(1)};

  // Payload count from the header, clamped to the committed bytes
  always_comb begin
    hdr_len = (mem_rdata == 8'd0) ? '0 : WW'(mem_rdata) - WW'(1);
    hdr_lim = (used == '0) ? '0 : WW'(used) - WW'(1);
    hdr_cl  = (hdr_len > hdr_lim) ? hdr_lim : hdr_len;
    n_clamp = hdr_cl[CW-1:0];
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = (item.action == ACT_POP) ? S_POP : S_PUSH;
        end
      end
      S_PUSH: begin
        state_next = cur.end_of_packet ? S_COMMIT : S_RESP;
      end
      S_COMMIT: begin
        state_next = S_RESP;
      end
      S_POP: begin
        if (cur.link_busy || (used == '0)) begin
          state_next = S_RESP;
        end else begin
          state_next = S_HDR;
        end
      end
      S_HDR: begin
        state_next = (n_clamp == '0) ? S_RESP : S_RD;
      end
      S_RD: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          state_next = (n_left == CW'(1)) ? S_IDLE : S_RD;
        end
      end
      S_RESP: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Datapath control and register next values
  always_comb begin
    rd_idx_next      = rd_idx;
    wr_idx_next      = wr_idx;
    used_next        = used;
    pcount_next      = pcount;
    povf_next        = povf;
    cur_next         = cur;
    resp_status_next = resp_status;
    n_left_next      = n_left;
    ptr_next         = ptr;
    mem_we           = 1'b0;
    mem_waddr        = wr_idx;
    mem_wdata        = cur.data_byte;
    mem_re           = 1'b0;
    mem_raddr        = rd_idx;
    add_a            = wr_idx;
    add_b            = pcount;
    load_res         = 1'b0;
    result_next      = result;

    case (state)
      S_IDLE: begin
        if (item_valid) begin
          cur_next = item;
        end
      end
      S_PUSH: begin
        // Stage the byte just past the reserved header slot
        add_a            = wr_idx;
        add_b            = pcount;
        resp_status_next = STAT_OK;
        if (!povf && fits) begin
          mem_we      = 1'b1;
          mem_waddr   = add_sum;
          mem_wdata   = cur.data_byte;
          pcount_next = pcount + CW'(1);
        end else begin
          povf_next = 1'b1;
        end
      end
      S_COMMIT: begin
        add_a = wr_idx;
        add_b = pcount;
        if (povf) begin
          resp_status_next = STAT_REJECT;
        end else begin
          mem_we           = 1'b1;
          mem_waddr        = wr_idx;
          mem_wdata        = hdr_wide[7:0];
          wr_idx_next      = add_sum;
          used_next        = used + pcount + CW'(1);
          resp_status_next = STAT_OK;
        end
        pcount_next = '0;
        povf_next   = 1'b0;
      end
      S_POP: begin
        ptr_next = rd_idx;
        if (cur.link_busy) begin
          resp_status_next = STAT_BUSY;
        end else if (used == '0) begin
          resp_status_next = STAT_EMPTY;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = rd_idx;
        end
      end
      S_HDR: begin
        // Release the packet before streaming so free_space shows the final value
        add_a            = rd_idx;
        add_b            = n_clamp;
        rd_idx_next      = add_sum;
        used_next        = used - n_clamp - CW'(1);
        n_left_next      = n_clamp;
        resp_status_next = STAT_EMPTY;
      end
      S_RD: begin
        add_a     = ptr;
        add_b     = '0;
        ptr_next  = add_sum;
        mem_re    = 1'b1;
        mem_raddr = add_sum;
      end
      S_EMIT: begin
        if (out_free) begin
          load_res               = 1'b1;
          result_next.out_byte   = mem_rdata;
          result_next.byte_valid = 1'b1;
          result_next.last       = (n_left == CW'(1));
          result_next.status     = STAT_OK;
          result_next.free_space = free7;
          n_left_next            = n_left - CW'(1);
        end
      end
      S_RESP: begin
        if (out_free) begin
          load_res               = 1'b1;
          result_next.out_byte   = 8'd0;
          result_next.byte_valid = 1'b0;
          result_next.last       = 1'b1;
          result_next.status     = resp_status;
          result_next.free_space = free7;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rd_idx       <= '0;
      wr_idx       <= '0;
      used         <= '0;
      pcount       <= '0;
      povf         <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_idx <= rd_idx_next;
      wr_idx <= wr_idx_next;
      used   <= used_next;
      pcount <= pcount_next;
      povf   <= povf_next;
      if (load_res) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur         <= cur_next;
    resp_status <= resp_status_next;
    n_left      <= n_left_next;
    ptr         <= ptr_next;
    result      <= result_next;
  end

  // The ring never fills completely
  assert property (@(posedge clk) disable iff (rst) used < CW'(RING_DEPTH))
    else $error("ring occupancy reached the full depth");

  // Staged bytes plus their header always fit beside the committed packets
  assert property (@(posedge clk) disable iff (rst)
    ((CW+1)'(pcount) + (CW+1)'(used)) <= (CW+1)'(RING_DEPTH - 1))
    else $error("staged packet overruns the free space");

  // Empty by count matches empty by pointers
  assert property (@(posedge clk) disable iff (rst) (used == '0) == (rd_idx == wr_idx))
    else $error("occupancy count disagrees with ring pointers");

  // A streamed byte always reports status ok
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.byte_valid) |-> (result.status == STAT_OK))
    else $error("payload byte carries a non-ok status");

endmodule

>>> src/lpr_ring_mem.sv
`timescale 1ns / 1ps
// Byte store of the ring: one write port, one read port with registered data.
module lpr_ring_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/lpr_mod_add.sv
`timescale 1ns / 1ps
// Shared index adder: a + b + 1, wrapped once around the ring depth.
module lpr_mod_add #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic [AW-1:0] a,
  input  logic [CW-1:0] b,
  output logic [AW-1:0] sum
);

  logic [CW:0] raw;
  logic [CW:0] wrapped;

  // Operands stay below the depth, so one compare and subtract suffices.
  always_comb begin
    raw     = (CW+1)'(a) + (CW+1)'(b) + (CW+1)'(1);
    wrapped = (raw >= (CW+1)'(DEPTH)) ? raw - (CW+1)'(DEPTH) : raw;
    sum     = wrapped[AW-1:0];
  end

endmodule
